// ===== design/capped_gap_time_axis_mapper_top_macros.svh =====
// Assertion macros shared by the checker of the time axis mapper.
`ifndef CAPPED_GAP_TIME_AXIS_MAPPER_TOP_MACROS_SVH
`define CAPPED_GAP_TIME_AXIS_MAPPER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CGTAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CGTAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/cgtam_pkg.sv =====
// Types, constants and helper functions of the time axis mapper.
package cgtam_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int TIME_W      = 34;
    localparam int POS_W       = 48;
    localparam int CAP_W       = 20;
    localparam int SCALE_W     = 16;
    localparam int PROD_W      = CAP_W + SCALE_W;
    localparam int MD_W        = TIME_W + POS_W;
    localparam int STEP_SHL    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int STEP_SHR    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    // Request codes.
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_BUILD  = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    // Status codes.
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_FULL    = 2'd1;
    localparam logic [1:0] STS_NOBUILD = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_MIN_TIME = 2'd0;
    localparam logic [1:0] REG_MAX_TIME = 2'd1;
    localparam logic [1:0] REG_GAP_CAP  = 2'd2;
    localparam logic [1:0] REG_SCALE    = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR0,
        ST_CLR1,
        ST_INS_SCAN,
        ST_INS_CHK,
        ST_INS_DEC,
        ST_INS_SHRD,
        ST_INS_SHWR,
        ST_INS_PUT,
        ST_BLD_START,
        ST_BLD_PREV,
        ST_BLD_LOOP,
        ST_BLD_MUL,
        ST_BLD_ADD,
        ST_Q_T0,
        ST_Q_TL,
        ST_Q_CLAMP,
        ST_Q_SRCH,
        ST_Q_SCHK,
        ST_Q_PA,
        ST_Q_PB,
        ST_Q_MD,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    // Operands handed to the multiply-divide unit.
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] a;
        logic [POS_W-1:0]  b;
        logic [TIME_W-1:0] d;
    } md_req_t;

    // Scale an exact Q.16 step to the position format.
    function automatic logic [POS_W-1:0] step_of(input logic [PROD_W-1:0] prod);
        logic [POS_W-1:0] wide;
        wide = POS_W'(prod);
        return (wide << STEP_SHL) >> STEP_SHR;
    endfunction

endpackage

// ===== design/cgtam_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cgtam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/cgtam_muldiv.sv =====
// Bit-serial unit that forms a*b exactly and divides it by d with truncation.
module cgtam_muldiv
    import cgtam_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  md_req_t          req,
    output logic             done,
    output logic [POS_W-1:0] q
);

    localparam int STEP_W = $clog2(MD_W + 1);

    md_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [TIME_W-1:0] a_reg, a_next;
    logic [POS_W-1:0]  b_reg, b_next;
    logic [TIME_W-1:0] d_reg, d_next;
    logic [MD_W-1:0]   acc_reg, acc_next;
    logic [TIME_W-1:0] r_reg, r_next;
    logic [POS_W-1:0]  q_reg, q_next;
    logic [TIME_W:0]   r_try;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        acc_reg <= acc_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
    end

    // One multiplier bit per cycle, then one quotient bit per cycle.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        acc_next   = acc_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        r_try      = {r_reg, acc_reg[MD_W-1]};
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.a;
                    b_next     = req.b;
                    d_next     = req.d;
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                acc_next = (acc_reg << 1)
                         + (a_reg[TIME_W-1] ? MD_W'(b_reg) : MD_W'(0));
                a_next   = a_reg << 1;
                if (step_reg == STEP_W'(TIME_W - 1))
                begin
                    step_next  = '0;
                    r_next     = '0;
                    q_next     = '0;
                    state_next = MD_DIV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            MD_DIV:
            begin
                acc_next = acc_reg << 1;
                if (r_try >= {1'b0, d_reg})
                begin
                    r_next = TIME_W'(r_try - {1'b0, d_reg});
                    q_next = {q_reg[POS_W-2:0], 1'b1};
                end
                else
                begin
                    r_next = r_try[TIME_W-1:0];
                    q_next = {q_reg[POS_W-2:0], 1'b0};
                end
                if (step_reg == STEP_W'(MD_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ===== design/capped_gap_time_axis_mapper_top.sv =====
// Top level of the capped-gap time axis mapper: registers, sequencer and memories.
//
// Usage: a request word (req_type, time_value) is taken when start is high and
// busy is low. busy stays high until the result word has been shown: done is
// high for exactly one cycle with position, status and entry_count, and busy
// falls in the next cycle. The receiver cannot stall; done is not held.
// Each request is carried out by the sequencer step by step, every memory read
// going through the single registered read port of each table memory: clear
// writes both seeds; build walks the table once, unless it is empty; insert
// scans for its place and shifts older entries down, the scan and the shift
// together visiting every entry once with a read and a compare or a write;
// query clamps at either end or runs a binary search, then interpolates with
// the bit-serial multiply and the restoring divide.
// Only one request is in work at a time.
// Configuration is written through the APB port (8-byte register spacing,
// 64-bit data); the user must write it only while the block is idle, as the
// block itself does not enforce this. Reads return the register value.
// Reset empties the table and marks positions as not built; the table memories
// are not cleared, as no entry is read before it is written.
module capped_gap_time_axis_mapper_top
    import cgtam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        req_type,
    input  logic [TIME_W-1:0] time_value,
    output logic              done,
    output logic [POS_W-1:0]  position,
    output logic [1:0]        status,
    output logic [CNT_W-1:0]  entry_count,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    // Configuration registers.
    logic [TIME_W-1:0]  min_time_reg;
    logic [TIME_W-1:0]  max_time_reg;
    logic [CAP_W-1:0]   gap_cap_reg;
    logic [SCALE_W-1:0] scale_reg;

    // Sequencer state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              built_reg, built_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  sidx_reg, sidx_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [TIME_W-1:0] prev_reg, prev_next;
    logic [TIME_W-1:0] ta_reg, ta_next;
    logic [TIME_W-1:0] tb_reg, tb_next;
    logic [POS_W-1:0]  pa_reg, pa_next;
    logic [POS_W-1:0]  acc_reg, acc_next;
    logic [POS_W-1:0]  prod_reg, prod_next;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;
    logic [1:0]        res_sts_reg, res_sts_next;

    // Memory ports.
    logic              t_we, p_we;
    logic [ADDR_W-1:0] t_waddr, t_raddr, p_waddr, p_raddr;
    logic [TIME_W-1:0] t_wdata, t_rdata;
    logic [POS_W-1:0]  p_wdata, p_rdata;

    // Helpers.
    md_req_t           md_req;
    logic              md_done;
    logic [POS_W-1:0]  md_q;
    logic [TIME_W-1:0] seed_hi;
    logic [TIME_W-1:0] gap;
    logic [CAP_W-1:0]  gap_capped;
    logic [POS_W:0]    acc_sum;
    logic [CNT_W-1:0]  last_cnt;
    logic [CNT_W-1:0]  mid_sum;
    logic              cfg_wr;

    cgtam_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_DEPTH)) u_times (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    cgtam_ram #(.WIDTH(POS_W), .DEPTH(TABLE_DEPTH)) u_positions (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    cgtam_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .done  (md_done),
        .q     (md_q)
    );

    // Configuration write and read.
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_time_reg <= TIME_W'(0);
            max_time_reg <= TIME_W'(1);
            gap_cap_reg  <= CAP_W'(86400);
            scale_reg    <= SCALE_W'(1311);
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                REG_MIN_TIME: min_time_reg <= pwdata[TIME_W-1:0];
                REG_MAX_TIME: max_time_reg <= pwdata[TIME_W-1:0];
                REG_GAP_CAP:  gap_cap_reg  <= pwdata[CAP_W-1:0];
                REG_SCALE:    scale_reg    <= pwdata[SCALE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_MIN_TIME: prdata = 64'(min_time_reg);
            REG_MAX_TIME: prdata = 64'(max_time_reg);
            REG_GAP_CAP:  prdata = 64'(gap_cap_reg);
            REG_SCALE:    prdata = 64'(scale_reg);
            default:      prdata = '0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            built_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            built_reg <= built_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        sidx_reg    <= sidx_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        t_reg       <= t_next;
        prev_reg    <= prev_next;
        ta_reg      <= ta_next;
        tb_reg      <= tb_next;
        pa_reg      <= pa_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        res_pos_reg <= res_pos_next;
        res_sts_reg <= res_sts_next;
    end

    // Shared arithmetic.
    assign seed_hi    = (max_time_reg == min_time_reg) ? min_time_reg + 1'b1 : max_time_reg;
    assign gap        = prev_reg - t_rdata;
    assign gap_capped = (gap < TIME_W'(gap_cap_reg)) ? gap[CAP_W-1:0] : gap_cap_reg;
    assign acc_sum    = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign last_cnt   = cnt_reg - 1'b1;
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};

    // Sequencer: next state, memory accesses and results.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        built_next   = built_reg;
        idx_next     = idx_reg;
        sidx_next    = sidx_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        t_next       = t_reg;
        prev_next    = prev_reg;
        ta_next      = ta_reg;
        tb_next      = tb_reg;
        pa_next      = pa_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        res_pos_next = res_pos_reg;
        res_sts_next = res_sts_reg;
        t_we         = 1'b0;
        t_waddr      = '0;
        t_wdata      = '0;
        t_raddr      = '0;
        p_we         = 1'b0;
        p_waddr      = '0;
        p_wdata      = '0;
        p_raddr      = '0;
        md_req       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    t_next       = time_value;
                    res_pos_next = '0;
                    res_sts_next = STS_OK;
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            state_next = ST_CLR0;
                        end
                        REQ_INSERT:
                        begin
                            idx_next   = '0;
                            state_next = ST_INS_SCAN;
                        end
                        REQ_BUILD:
                        begin
                            state_next = ST_BLD_START;
                        end
                        default:
                        begin
                            // Query.
                            if (!built_reg)
                            begin
                                res_sts_next = STS_NOBUILD;
                                state_next   = ST_FIN;
                            end
                            else if (cnt_reg == '0)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                t_raddr    = '0;
                                state_next = ST_Q_T0;
                            end
                        end
                    endcase
                end
            end

            // Clear writes both seeds, newer one first.
            ST_CLR0:
            begin
                t_we       = 1'b1;
                t_waddr    = ADDR_W'(0);
                t_wdata    = (seed_hi > min_time_reg) ? seed_hi : min_time_reg;
                state_next = ST_CLR1;
            end
            ST_CLR1:
            begin
                t_we       = 1'b1;
                t_waddr    = ADDR_W'(1);
                t_wdata    = (seed_hi > min_time_reg) ? min_time_reg : seed_hi;
                cnt_next   = CNT_W'(2);
                built_next = 1'b0;
                state_next = ST_FIN;
            end

            // Insert scans for the first entry not newer than the time.
            ST_INS_SCAN:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = ST_INS_DEC;
                end
                else
                begin
                    t_raddr    = idx_reg[ADDR_W-1:0];
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK:
            begin
                if (t_rdata > t_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_INS_SCAN;
                end
                else if (t_rdata == t_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_INS_DEC;
                end
            end
            ST_INS_DEC:
            begin
                if (cnt_reg == CNT_W'(TABLE_DEPTH))
                begin
                    res_sts_next = STS_FULL;
                    state_next   = ST_FIN;
                end
                else
                begin
                    sidx_next  = cnt_reg;
                    state_next = ST_INS_SHRD;
                end
            end
            // Move older entries down by one, from the end.
            ST_INS_SHRD:
            begin
                if (sidx_reg == idx_reg)
                begin
                    state_next = ST_INS_PUT;
                end
                else
                begin
                    t_raddr    = ADDR_W'(sidx_reg - 1'b1);
                    state_next = ST_INS_SHWR;
                end
            end
            ST_INS_SHWR:
            begin
                t_we       = 1'b1;
                t_waddr    = sidx_reg[ADDR_W-1:0];
                t_wdata    = t_rdata;
                sidx_next  = sidx_reg - 1'b1;
                state_next = ST_INS_SHRD;
            end
            ST_INS_PUT:
            begin
                t_we       = 1'b1;
                t_waddr    = idx_reg[ADDR_W-1:0];
                t_wdata    = t_reg;
                cnt_next   = cnt_reg + 1'b1;
                built_next = 1'b0;
                state_next = ST_FIN;
            end

            // Build accumulates capped, scaled gaps along the table.
            ST_BLD_START:
            begin
                if (cnt_reg == '0)
                begin
                    built_next = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    p_we       = 1'b1;
                    p_waddr    = '0;
                    p_wdata    = '0;
                    t_raddr    = '0;
                    acc_next   = '0;
                    idx_next   = CNT_W'(1);
                    state_next = ST_BLD_PREV;
                end
            end
            ST_BLD_PREV:
            begin
                prev_next  = t_rdata;
                state_next = ST_BLD_LOOP;
            end
            ST_BLD_LOOP:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    built_next = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    t_raddr    = idx_reg[ADDR_W-1:0];
                    state_next = ST_BLD_MUL;
                end
            end
            ST_BLD_MUL:
            begin
                prev_next  = t_rdata;
                prod_next  = step_of(PROD_W'(gap_capped) * PROD_W'(scale_reg));
                state_next = ST_BLD_ADD;
            end
            ST_BLD_ADD:
            begin
                acc_next   = acc_sum[POS_W] ? {POS_W{1'b1}} : acc_sum[POS_W-1:0];
                p_we       = 1'b1;
                p_waddr    = idx_reg[ADDR_W-1:0];
                p_wdata    = acc_next;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_BLD_LOOP;
            end

            // Query: clamp at either end, else binary search and interpolate.
            ST_Q_T0:
            begin
                ta_next = t_rdata;
                if (t_reg >= t_rdata)
                begin
                    p_raddr    = '0;
                    state_next = ST_Q_CLAMP;
                end
                else
                begin
                    t_raddr    = last_cnt[ADDR_W-1:0];
                    state_next = ST_Q_TL;
                end
            end
            ST_Q_TL:
            begin
                tb_next = t_rdata;
                if (t_reg <= t_rdata)
                begin
                    p_raddr    = last_cnt[ADDR_W-1:0];
                    state_next = ST_Q_CLAMP;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = last_cnt[ADDR_W-1:0];
                    state_next = ST_Q_SRCH;
                end
            end
            ST_Q_CLAMP:
            begin
                res_pos_next = p_rdata;
                state_next   = ST_FIN;
            end
            ST_Q_SRCH:
            begin
                if (({1'b0, lo_reg} + 1'b1) < {1'b0, hi_reg})
                begin
                    t_raddr    = mid_sum[ADDR_W:1];
                    idx_next   = CNT_W'(mid_sum[ADDR_W:1]);
                    state_next = ST_Q_SCHK;
                end
                else
                begin
                    p_raddr    = lo_reg;
                    state_next = ST_Q_PA;
                end
            end
            ST_Q_SCHK:
            begin
                if (t_rdata >= t_reg)
                begin
                    lo_next = idx_reg[ADDR_W-1:0];
                    ta_next = t_rdata;
                end
                else
                begin
                    hi_next = idx_reg[ADDR_W-1:0];
                    tb_next = t_rdata;
                end
                state_next = ST_Q_SRCH;
            end
            ST_Q_PA:
            begin
                pa_next    = p_rdata;
                p_raddr    = hi_reg;
                state_next = ST_Q_PB;
            end
            ST_Q_PB:
            begin
                if (ta_reg == tb_reg)
                begin
                    res_pos_next = pa_reg;
                    state_next   = ST_FIN;
                end
                else
                begin
                    md_req.start = 1'b1;
                    md_req.a     = ta_reg - t_reg;
                    md_req.b     = p_rdata - pa_reg;
                    md_req.d     = ta_reg - tb_reg;
                    state_next   = ST_Q_MD;
                end
            end
            ST_Q_MD:
            begin
                if (md_done)
                begin
                    res_pos_next = pa_reg + md_q;
                    state_next   = ST_FIN;
                end
            end

            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result word.
    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_FIN);
    assign position    = res_pos_reg;
    assign status      = res_sts_reg;
    assign entry_count = cnt_reg;

endmodule

// ===== design/cgtam_checker.sv =====
// Port-level checker of the time axis mapper and its bind.
`include "capped_gap_time_axis_mapper_top_macros.svh"

module cgtam_checker
    import cgtam_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [POS_W-1:0]  position,
    input logic [1:0]        status,
    input logic [CNT_W-1:0]  entry_count
);

    // An accepted word makes the block busy.
    `CGTAM_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // A result is only shown while a word is in work.
    `CGTAM_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    // The block is free right after a result.
    `CGTAM_ASSERT_NXT(a_done_free, clk, rst_n, done, !busy)
    // A failed request carries no position, and the table never overfills.
    `CGTAM_ASSERT_IMP(a_fail_zero, clk, rst_n, done && (status != STS_OK),
        (position == '0) && (entry_count <= CNT_W'(TABLE_DEPTH)))

endmodule

bind capped_gap_time_axis_mapper_top cgtam_checker u_cgtam_checker (.*);

// ===== tb/capped_gap_time_axis_mapper_top_test.sv =====
// Self-checking testbench for the capped-gap time axis mapper with a built-in predictor.
module capped_gap_time_axis_mapper_top_test;
    import cgtam_pkg::*;

    localparam int IDLE_LIMIT   = 40000;
    localparam int RANDOM_ITEMS = 650;
    localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};
    localparam logic [POS_W-1:0]  POS_TOP  = {POS_W{1'b1}};

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [1:0]       sts;
        logic [CNT_W-1:0] cnt;
    } mapped_word_t;

    typedef struct packed {
        logic [1:0]        req;
        logic [TIME_W-1:0] tval;
        logic              fixed;
        mapped_word_t      res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        req_type;
    logic [TIME_W-1:0] time_value;
    logic              done;
    logic [POS_W-1:0]  position;
    logic [1:0]        status;
    logic [CNT_W-1:0]  entry_count;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [4:0]        paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    // Predictor copy of the configuration and the axis table.
    logic [TIME_W-1:0]  cfg_min;
    logic [TIME_W-1:0]  cfg_max;
    logic [CAP_W-1:0]   cfg_cap;
    logic [SCALE_W-1:0] cfg_scale;
    logic [TIME_W-1:0]  axis_times [TABLE_DEPTH];
    logic [POS_W-1:0]   axis_pos [TABLE_DEPTH];
    int                 axis_count;
    logic               axis_built;

    mapped_word_t pending_words[$];
    int           fail_count;
    int           idle_cycles;
    int           burst_left;
    int           sent_items;

    capped_gap_time_axis_mapper_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .time_value(time_value), .done(done),
        .position(position), .status(status), .entry_count(entry_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock with a period of two units.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Insert one time in newest-first order; returns the status code.
    function automatic logic [1:0] axis_insert(input logic [TIME_W-1:0] t);
        int p;
        p = 0;
        while (p < axis_count && axis_times[p] > t)
            p++;
        if (p < axis_count && axis_times[p] == t)
            return STS_OK;
        if (axis_count >= TABLE_DEPTH)
            return STS_FULL;
        for (int i = axis_count; i > p; i--)
            axis_times[i] = axis_times[i - 1];
        axis_times[p] = t;
        axis_count++;
        axis_built = 1'b0;
        return STS_OK;
    endfunction

    // Interpolated position of time t over the built table.
    function automatic logic [POS_W-1:0] axis_map(input logic [TIME_W-1:0] t);
        int lo;
        int hi;
        int mid;
        logic [MD_W-1:0] offset;
        lo = 0;
        hi = axis_count - 1;
        if (t >= axis_times[0])
            return axis_pos[0];
        if (t <= axis_times[hi])
            return axis_pos[hi];
        while (lo + 1 < hi)
        begin
            mid = (lo + hi) / 2;
            if (axis_times[mid] >= t)
                lo = mid;
            else
                hi = mid;
        end
        if (axis_times[lo] == axis_times[hi])
            return axis_pos[lo];
        offset = (MD_W'(axis_times[lo] - t) * MD_W'(axis_pos[hi] - axis_pos[lo]))
                 / MD_W'(axis_times[lo] - axis_times[hi]);
        return axis_pos[lo] + offset[POS_W-1:0];
    endfunction

    // Expected result word of one request; updates the predictor state.
    function automatic mapped_word_t axis_predict(input logic [1:0] req,
                                                  input logic [TIME_W-1:0] t);
        mapped_word_t w;
        logic [TIME_W-1:0] seed_hi;
        logic [POS_W-1:0]  run;
        logic [63:0]       stp;
        logic [TIME_W-1:0] gap;
        w = '0;
        case (req)
            REQ_CLEAR:
            begin
                seed_hi = (cfg_max == cfg_min) ? cfg_min + 1'b1 : cfg_max;
                axis_count = 0;
                axis_built = 1'b0;
                void'(axis_insert(cfg_min));
                void'(axis_insert(seed_hi));
            end
            REQ_INSERT:
                w.sts = axis_insert(t);
            REQ_BUILD:
            begin
                run = '0;
                if (axis_count > 0)
                    axis_pos[0] = '0;
                for (int i = 1; i < axis_count; i++)
                begin
                    gap = axis_times[i - 1] - axis_times[i];
                    stp = 64'(gap < TIME_W'(cfg_cap) ? gap : TIME_W'(cfg_cap)) * 64'(cfg_scale);
                    stp = (stp << STEP_SHL) >> STEP_SHR;
                    run = (stp > 64'(POS_TOP - run)) ? POS_TOP : run + stp[POS_W-1:0];
                    axis_pos[i] = run;
                end
                axis_built = 1'b1;
            end
            default:
            begin
                if (!axis_built)
                    w.sts = STS_NOBUILD;
                else if (axis_count > 0)
                    w.pos = axis_map(t);
            end
        endcase
        w.cnt = CNT_W'(axis_count);
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("error: %s got %0d, expected %0d", what, got, want);
        fail_count++;
    endtask

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected word, entry_count", 64'(entry_count), 64'd0);
            else
            begin
                if (position !== pending_words[0].pos)
                    report_mismatch("position", 64'(position), 64'(pending_words[0].pos));
                if (status !== pending_words[0].sts)
                    report_mismatch("status", 64'(status), 64'(pending_words[0].sts));
                if (entry_count !== pending_words[0].cnt)
                    report_mismatch("entry_count", 64'(entry_count),
                                    64'(pending_words[0].cnt));
                void'(pending_words.pop_front());
            end
        end
    end

    // Watchdog on cycles with no accepted request and no result word.
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("capped_gap_time_axis_mapper_top: mismatch");
            $finish;
        end
    end

    // Send one request word, with burst gaps ahead of it.
    task automatic send_word(input logic [1:0] req, input logic [TIME_W-1:0] t,
                             input logic fixed, input mapped_word_t fixed_res);
        mapped_word_t w;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        start <= 1'b1;
        req_type <= req;
        time_value <= t;
        do
            @(posedge clk);
        while (busy);
        w = axis_predict(req, t);
        pending_words.insert(pending_words.size(), fixed ? fixed_res : w);
        sent_items++;
    endtask

    // Hold off until every expected word has arrived.
    task automatic drain;
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_TIME: cfg_min = val[TIME_W-1:0];
            REG_MAX_TIME: cfg_max = val[TIME_W-1:0];
            REG_GAP_CAP:  cfg_cap = val[CAP_W-1:0];
            default:      cfg_scale = val[SCALE_W-1:0];
        endcase
    endtask

    task automatic set_config(input logic [TIME_W-1:0] mn, input logic [TIME_W-1:0] mx,
                              input logic [CAP_W-1:0] cap, input logic [SCALE_W-1:0] sc);
        drain();
        reg_write(REG_MIN_TIME, 64'(mn));
        reg_write(REG_MAX_TIME, 64'(mx));
        reg_write(REG_GAP_CAP, 64'(cap));
        reg_write(REG_SCALE, 64'(sc));
    endtask

    function automatic logic [TIME_W-1:0] any_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    // Times that land near the table contents, at the extremes, or anywhere.
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 5))
            0: return any_time();
            1: return ($urandom_range(0, 1) == 0) ? '0 : TIME_TOP;
            2: return cfg_min + $urandom_range(0, 3 * cfg_cap + 2);
            3: return axis_times[$urandom_range(0, axis_count - 1)];
            default:
                return axis_times[$urandom_range(0, axis_count - 1)]
                       + TIME_W'($urandom_range(0, 4000)) - TIME_W'(2000);
        endcase
    endfunction

    // Directed requests against the reset configuration.
    stim_row_t dir_rows [20] = '{
        '{REQ_QUERY,  34'd5,            1'b1, '{48'd0, STS_NOBUILD, 11'd0}},
        '{REQ_BUILD,  34'd0,            1'b1, '{48'd0, STS_OK,      11'd0}},
        '{REQ_QUERY,  34'd7,            1'b1, '{48'd0, STS_OK,      11'd0}},
        '{REQ_CLEAR,  34'h3_FFFF_FFFF,  1'b1, '{48'd0, STS_OK,      11'd2}},
        '{REQ_QUERY,  34'd0,            1'b1, '{48'd0, STS_NOBUILD, 11'd2}},
        '{REQ_INSERT, 34'h3_FFFF_FFFF,  1'b1, '{48'd0, STS_OK,      11'd3}},
        '{REQ_INSERT, 34'h3_FFFF_FFFF,  1'b1, '{48'd0, STS_OK,      11'd3}},
        '{REQ_INSERT, 34'd0,            1'b1, '{48'd0, STS_OK,      11'd3}},
        '{REQ_INSERT, 34'd1000,         1'b1, '{48'd0, STS_OK,      11'd4}},
        '{REQ_INSERT, 34'd500000,       1'b1, '{48'd0, STS_OK,      11'd5}},
        '{REQ_BUILD,  34'h2_AAAA_5555,  1'b1, '{48'd0, STS_OK,      11'd5}},
        '{REQ_QUERY,  34'h3_FFFF_FFFF,  1'b1, '{48'd0, STS_OK,      11'd5}},
        '{REQ_QUERY,  34'd0,            1'b0, '0},
        '{REQ_QUERY,  34'd1,            1'b0, '0},
        '{REQ_QUERY,  34'd700,          1'b0, '0},
        '{REQ_QUERY,  34'd300000,       1'b0, '0},
        '{REQ_QUERY,  34'h2_0000_0000,  1'b0, '0},
        '{REQ_INSERT, 34'd2000,         1'b1, '{48'd0, STS_OK,      11'd6}},
        '{REQ_QUERY,  34'd2000,         1'b1, '{48'd0, STS_NOBUILD, 11'd6}},
        '{REQ_BUILD,  34'd1,            1'b1, '{48'd0, STS_OK,      11'd6}}
    };

    initial
    begin
        int phase;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_CLEAR;
        time_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_min = '0;
        cfg_max = 34'd1;
        cfg_cap = 20'd86400;
        cfg_scale = 16'd1311;
        axis_count = 0;
        axis_built = 1'b0;
        fail_count = 0;
        burst_left = 0;
        sent_items = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].req, dir_rows[i].tval, dir_rows[i].fixed, dir_rows[i].res);
        send_word(REQ_QUERY, 34'd1500, 1'b0, '0);

        // Fill the table to its depth, then one insert too many and a duplicate.
        set_config(34'd100, 34'd50, 20'hFFFFF, 16'hFFFF);
        send_word(REQ_CLEAR, '0, 1'b0, '0);
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            send_word(REQ_INSERT, 34'd1000 + 34'(i) * 34'd777 + $urandom_range(0, 700),
                      1'b0, '0);
        send_word(REQ_INSERT, 34'd60, 1'b1, '{48'd0, STS_FULL, 11'd1024});
        send_word(REQ_INSERT, 34'd100, 1'b1, '{48'd0, STS_OK, 11'd1024});
        send_word(REQ_BUILD, '0, 1'b0, '0);
        repeat (6) send_word(REQ_QUERY, pick_time(), 1'b0, '0);

        // Random phases: configuration, clear, inserts, build, queries and noise.
        sent_items = 0;
        phase = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            case (phase)
                0: set_config(34'd12345, 34'd12345, 20'd0, 16'd0);
                1: set_config(TIME_TOP - 1'b1, TIME_TOP - 1'b1, 20'hFFFFF, 16'hFFFF);
                2: set_config(34'd900000, 34'd10, 20'd1, 16'd1);
                3: set_config('0, TIME_TOP - 1'b1, 20'd86400, 16'd1311);
                default:
                    if ($urandom_range(0, 2) == 0)
                    begin
                        cfg_min = any_time() % (TIME_TOP);
                        set_config(cfg_min,
                                   ($urandom_range(0, 4) == 0) ? cfg_min
                                       : any_time() % TIME_TOP,
                                   ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                       : 20'($urandom_range(0, 5000)),
                                   16'($urandom));
                    end
            endcase
            phase++;
            send_word(REQ_CLEAR, any_time(), 1'b0, '0);
            repeat ($urandom_range(0, 14))
                send_word(REQ_INSERT, pick_time(), 1'b0, '0);
            if ($urandom_range(0, 3) == 0)
                send_word(REQ_QUERY, pick_time(), 1'b0, '0);
            send_word(REQ_BUILD, any_time(), 1'b0, '0);
            repeat ($urandom_range(4, 14))
            begin
                case ($urandom_range(0, 9))
                    0: send_word(REQ_INSERT, pick_time(), 1'b0, '0);
                    1: send_word(REQ_BUILD, any_time(), 1'b0, '0);
                    2: send_word(2'($urandom), any_time(), 1'b0, '0);
                    default: send_word(REQ_QUERY, pick_time(), 1'b0, '0);
                endcase
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("capped_gap_time_axis_mapper_top: match");
        else
            $display("capped_gap_time_axis_mapper_top: mismatch");
        $finish;
    end

endmodule
